>>> sv/wtrs_pkg.sv
// Package for the wavelet tree rank/select block: field widths, operation codes
// and the command/status structs between the controller and the datapath.
// No dependencies.
package wtrs_pkg;

  localparam int MAX_ITEMS_DEF   = 1024;
  localparam int MAX_SYMBOLS_DEF = 16;

  localparam int FUNC_W  = 3;
  localparam int SYM_W   = 4;
  localparam int POS_W   = 11;
  localparam int ANS_W   = 11;
  localparam int ALPHA_W = 5;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_KTH    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_RANK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_COUNT  = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic load;     // latch request fields
    logic init;     // start a tree walk at the root
    logic issue_a;  // read first prefix count of the level
    logic issue_b;  // read second prefix count of the level
    logic step;     // descend one level
    logic leaf;     // leaf action for range count
    logic restart;  // second walk of range count
    logic retire;   // load the result register
  } wtrs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bad;       // request refused
    logic trivial;   // answer zero without a walk
    logic leaf_now;  // walk has reached a leaf
    logic two_pass;  // range count still owes its second walk
    logic slot_free; // result register can take a result
  } wtrs_stat_t;

endpackage

>>> sv/wavelet_tree_rank_select.sv
// A refused or trivial request skips the tree walk; any other request walks the tree levels
// on its path, at most ceil(log2(alphabet_size)) of them. Range count walks twice.
// One request at a time; the prefix count RAM is read twice per level.
// The result register lets a new request enter while the last result waits.
// Synchronous active-high reset empties the store and sets the alphabet to 16.
module wavelet_tree_rank_select #(
  parameter int MAX_ITEMS   = wtrs_pkg::MAX_ITEMS_DEF,
  parameter int MAX_SYMBOLS = wtrs_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [wtrs_pkg::FUNC_W-1:0]  func,
  input  logic [wtrs_pkg::SYM_W-1:0]   sym,
  input  logic [wtrs_pkg::SYM_W-1:0]   sym_high,
  input  logic [wtrs_pkg::POS_W-1:0]   kth,
  input  logic [wtrs_pkg::POS_W-1:0]   pos_lo,
  input  logic [wtrs_pkg::POS_W-1:0]   pos_hi,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [wtrs_pkg::ANS_W-1:0]   answer,
  output logic                         fault,
  input  logic                         cfg_we,
  input  logic [wtrs_pkg::ALPHA_W-1:0] cfg_wdata
);
  import wtrs_pkg::*;

  wtrs_cmd_t  cmd;
  wtrs_stat_t stat;

  wtrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wtrs_datapath #(.MAX_ITEMS(MAX_ITEMS), .MAX_SYMBOLS(MAX_SYMBOLS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .func      (func),
    .sym       (sym),
    .sym_high  (sym_high),
    .kth       (kth),
    .pos_lo    (pos_lo),
    .pos_hi    (pos_hi),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .answer    (answer),
    .fault     (fault)
  );

endmodule

>>> sv/wtrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wtrs_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/wtrs_datapath.sv
// Datapath of the wavelet tree block: request registers, walk registers,
// per-node fill counts, prefix count RAM and result register.
// Depends on wtrs_pkg and wtrs_ram.
module wtrs_datapath #(
  parameter int MAX_ITEMS   = wtrs_pkg::MAX_ITEMS_DEF,
  parameter int MAX_SYMBOLS = wtrs_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [wtrs_pkg::FUNC_W-1:0]   func,
  input  logic [wtrs_pkg::SYM_W-1:0]    sym,
  input  logic [wtrs_pkg::SYM_W-1:0]    sym_high,
  input  logic [wtrs_pkg::POS_W-1:0]    kth,
  input  logic [wtrs_pkg::POS_W-1:0]    pos_lo,
  input  logic [wtrs_pkg::POS_W-1:0]    pos_hi,
  input  logic                          cfg_we,
  input  logic [wtrs_pkg::ALPHA_W-1:0]  cfg_wdata,
  input  wtrs_pkg::wtrs_cmd_t           cmd,
  output wtrs_pkg::wtrs_stat_t          stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wtrs_pkg::ANS_W-1:0]    answer,
  output logic                          fault
);
  import wtrs_pkg::*;

  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int LR_W      = $clog2(MAX_SYMBOLS);
  localparam int V_W       = LR_W + 1;
  localparam int SLOTS     = 2 * MAX_SYMBOLS;
  localparam int U_W       = $clog2(SLOTS);
  localparam int AW        = U_W + CNT_W;
  localparam int RAM_DEPTH = 1 << AW;
  localparam int ALPHA_RST = (MAX_SYMBOLS < 16) ? MAX_SYMBOLS : 16;

  // Request fields
  logic [FUNC_W-1:0] op_func;
  logic [SYM_W-1:0]  op_sym;
  logic [SYM_W-1:0]  op_symh;
  logic [POS_W-1:0]  op_k;
  logic [POS_W-1:0]  op_lo;
  logic [POS_W-1:0]  op_hi;

  // Store state
  logic [V_W-1:0]   alpha;
  logic [CNT_W-1:0] item_cnt;
  logic [CNT_W-1:0] occ [SLOTS];

  // Walk state
  logic [LR_W-1:0]  l, r;
  logic [U_W-1:0]   u;
  logic [CNT_W-1:0] a, b, k, acc, za;
  logic [V_W-1:0]   v;
  logic             pass, a_zero, b_zero;

  // RAM
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [CNT_W-1:0] ram_wdata, ram_rdata;

  logic [CNT_W-1:0] occ_u, idx_a, idx_b, zb, cnt;
  logic [LR_W:0]    lr_sum;
  logic [LR_W-1:0]  m;
  logic             go_left, sym_le_m;
  logic [31:0]      cfg32, v_hi32, v_lo32, s32;
  logic [V_W-1:0]   v_first, v_second;
  logic             bad, trivial;

  wtrs_ram #(.WIDTH(CNT_W), .DEPTH(RAM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Request checks
  always_comb begin
    bad     = 1'b0;
    trivial = 1'b0;
    case (op_func)
      FN_APPEND: bad = (32'(item_cnt) >= MAX_ITEMS) || (32'(op_sym) >= 32'(alpha));
      FN_REMOVE: bad = (item_cnt == '0);
      FN_KTH:    bad = (op_lo > op_hi) || (32'(op_hi) > 32'(item_cnt)) || (op_k == '0)
                       || (op_k > op_hi - op_lo);
      FN_RANK:   bad = (32'(op_hi) > 32'(item_cnt)) || (32'(op_sym) >= 32'(alpha));
      FN_COUNT: begin
        bad     = (op_lo > op_hi) || (32'(op_hi) > 32'(item_cnt));
        trivial = (op_symh < op_sym) || (op_lo == op_hi);
      end
      default:   bad = 1'b1;
    endcase
  end

  // Value bounds for the two range count walks, clamped to the alphabet
  always_comb begin
    s32      = 32'(alpha);
    v_hi32   = 32'(op_symh) + 32'd1;
    v_lo32   = 32'(op_sym);
    v_first  = V_W'((v_hi32 < s32) ? v_hi32 : s32);
    v_second = V_W'((v_lo32 < s32) ? v_lo32 : s32);
    cfg32    = 32'(cfg_wdata);
  end

  // Per-level addressing and split decision
  always_comb begin
    occ_u    = occ[u];
    lr_sum   = {1'b0, l} + {1'b0, r};
    m        = lr_sum[LR_W:1];
    sym_le_m = 32'(op_sym) <= 32'(m);
    zb       = b_zero ? '0 : ram_rdata;
    cnt      = zb - za;
    case (op_func)
      FN_APPEND: begin idx_a = occ_u;           idx_b = occ_u; end
      FN_REMOVE: begin idx_a = occ_u - 1'b1;    idx_b = occ_u; end
      default:   begin idx_a = a;               idx_b = b;     end
    endcase
    case (op_func)
      FN_APPEND: go_left = sym_le_m;
      FN_REMOVE: go_left = (cnt != '0);
      FN_KTH:    go_left = (k <= cnt);
      FN_RANK:   go_left = sym_le_m;
      default:   go_left = !(32'(v) > 32'(m));
    endcase
    ram_raddr = cmd.issue_b ? {u, idx_b} : {u, idx_a};
    ram_we    = cmd.step && (op_func == FN_APPEND);
    ram_waddr = {u, occ_u + 1'b1};
    ram_wdata = za + CNT_W'(sym_le_m);
  end

  assign stat.bad       = bad;
  assign stat.trivial   = trivial;
  assign stat.leaf_now  = (l == r);
  assign stat.two_pass  = (op_func == FN_COUNT) && !pass;
  assign stat.slot_free = !out_valid || out_ready;

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_func <= func;
      op_sym  <= sym;
      op_symh <= sym_high;
      op_k    <= kth;
      op_lo   <= pos_lo;
      op_hi   <= pos_hi;
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    if (cmd.init || cmd.restart) begin
      l <= '0;
      r <= LR_W'(alpha - 1'b1);
      u <= U_W'(1);
      b <= CNT_W'(op_hi);
      a <= (op_func == FN_RANK) ? '0 : CNT_W'(op_lo);
    end
    if (cmd.init) begin
      k    <= CNT_W'(op_k);
      v    <= v_first;
      pass <= 1'b0;
      acc  <= '0;
    end
    if (cmd.restart) begin
      v    <= v_second;
      pass <= 1'b1;
    end
    if (cmd.issue_a) begin
      a_zero <= (idx_a == '0);
    end
    if (cmd.issue_b) begin
      za     <= a_zero ? '0 : ram_rdata;
      b_zero <= (idx_b == '0);
    end
    if (cmd.step) begin
      u <= {u[U_W-2:0], !go_left};
      if (go_left) begin
        r <= m;
        a <= za;
        b <= zb;
      end else begin
        l <= m + 1'b1;
        a <= a - za;
        b <= b - zb;
        if (op_func == FN_KTH) begin
          k <= k - cnt;
        end
        if (op_func == FN_COUNT) begin
          acc <= pass ? acc - cnt : acc + cnt;
        end
      end
    end
    if (cmd.leaf && (op_func == FN_COUNT) && (32'(l) < 32'(v))) begin
      acc <= pass ? acc - (b - a) : acc + (b - a);
    end
  end

  // Store state: alphabet, item count and node fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha    <= V_W'(ALPHA_RST);
      item_cnt <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        occ[i] <= '0;
      end
    end else begin
      if (cfg_we && (item_cnt == '0)) begin
        alpha <= (cfg32 == 32'd0) ? V_W'(1) :
                 (cfg32 > MAX_SYMBOLS) ? V_W'(MAX_SYMBOLS) : V_W'(cfg32);
      end
      if (cmd.step && (op_func == FN_APPEND)) begin
        occ[u] <= occ_u + 1'b1;
      end
      if (cmd.step && (op_func == FN_REMOVE)) begin
        occ[u] <= occ_u - 1'b1;
      end
      if (cmd.retire && !bad && (op_func == FN_APPEND)) begin
        item_cnt <= item_cnt + 1'b1;
      end
      if (cmd.retire && !bad && (op_func == FN_REMOVE)) begin
        item_cnt <= item_cnt - 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.retire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.retire) begin
      fault <= bad;
      if (bad || trivial) begin
        answer <= '0;
      end else begin
        case (op_func)
          FN_KTH:   answer <= ANS_W'(r);
          FN_RANK:  answer <= ANS_W'(b);
          FN_COUNT: answer <= ANS_W'(acc);
          default:  answer <= '0;
        endcase
      end
    end
  end

endmodule

>>> sv/wtrs_ctrl.sv
// Controller of the wavelet tree block: sequences checks, level reads and
// descents, the second range count walk and result hand-off.
// Depends on wtrs_pkg.
module wtrs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  wtrs_pkg::wtrs_stat_t stat,
  output wtrs_pkg::wtrs_cmd_t  cmd
);
  import wtrs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_LVL   = 7'b0000100,
    S_RDB   = 7'b0001000,
    S_STEP  = 7'b0010000,
    S_LEAF  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.bad || stat.trivial) begin
          state_next = S_DONE;
        end else begin
          cmd.init   = 1'b1;
          state_next = S_LVL;
        end
      end
      S_LVL: begin
        if (stat.leaf_now) begin
          state_next = S_LEAF;
        end else begin
          cmd.issue_a = 1'b1;
          state_next  = S_RDB;
        end
      end
      S_RDB: begin
        cmd.issue_b = 1'b1;
        state_next  = S_STEP;
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        state_next = S_LVL;
      end
      S_LEAF: begin
        cmd.leaf = 1'b1;
        if (stat.two_pass) begin
          cmd.restart = 1'b1;
          state_next  = S_LVL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.slot_free) begin
          cmd.retire = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> sv/wtrs_checker.sv
// Port-level checks for the wavelet tree block, bound to the top level.
// Depends on wtrs_pkg.
module wtrs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [wtrs_pkg::ANS_W-1:0]   answer,
  input logic                         fault
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(answer) && $stable(fault))
    else $error("result changed while stalled");

  // Refused requests answer zero
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault |-> answer == '0)
    else $error("non-zero answer with fault");

  // One request at a time: busy right after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // No result straight out of reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A fresh request cannot produce a result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result too early");

endmodule

bind wavelet_tree_rank_select wtrs_checker u_wtrs_checker (.*);

>>> tb/sv/tb_top.sv
// Self-checking testbench for wavelet_tree_rank_select: random and directed requests,
// predicted against a plain symbol array kept alongside the block.
// Depends on wtrs_pkg and wavelet_tree_rank_select.
`timescale 1ns / 100ps

module tb_top;
  import wtrs_pkg::*;

  localparam int CAP = MAX_ITEMS_DEF;
  localparam int DRAIN_WAIT = 40;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [SYM_W-1:0]  sym;
    logic [SYM_W-1:0]  sym_high;
    logic [POS_W-1:0]  kth;
    logic [POS_W-1:0]  pos_lo;
    logic [POS_W-1:0]  pos_hi;
  } req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [FUNC_W-1:0] func = '0;
  logic [SYM_W-1:0] sym = '0;
  logic [SYM_W-1:0] sym_high = '0;
  logic [POS_W-1:0] kth = '0;
  logic [POS_W-1:0] pos_lo = '0;
  logic [POS_W-1:0] pos_hi = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ANS_W-1:0] answer;
  logic fault;
  logic cfg_we = 1'b0;
  logic [ALPHA_W-1:0] cfg_wdata = '0;

  // Shadow of the stored sequence and alphabet
  int seq_syms[CAP];
  int seq_len = 0;
  int alpha = 16;

  // Expected results, oldest first
  logic [ANS_W-1:0] exp_answer[$];
  logic exp_fault[$];

  int tx_idle_pct = 7;
  int rx_idle_pct = 76;
  int hold_left = 0;
  int mismatches = 0;
  int results_seen = 0;
  int faults_seen = 0;
  int func_seen[8];

  wavelet_tree_rank_select i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .sym(sym), .sym_high(sym_high), .kth(kth),
    .pos_lo(pos_lo), .pos_hi(pos_hi),
    .out_valid(out_valid), .out_ready(out_ready),
    .answer(answer), .fault(fault),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the result of one request and update the shadow sequence
  function automatic void apply_request(input req_t r, output logic [ANS_W-1:0] ans,
                                        output logic flt);
    int a, b, k, acc, v, n;
    int hist[16];
    a = r.pos_lo;
    b = r.pos_hi;
    k = r.kth;
    flt = 1'b0;
    ans = '0;
    n = 0;
    foreach (hist[i]) hist[i] = 0;
    case (r.func)
      FN_APPEND: begin
        if (seq_len >= CAP || r.sym >= alpha) flt = 1'b1;
        else begin
          seq_syms[seq_len] = r.sym;
          seq_len++;
        end
      end
      FN_REMOVE: begin
        if (seq_len == 0) flt = 1'b1;
        else seq_len--;
      end
      FN_KTH: begin
        if (a > b || b > seq_len || k < 1 || k > b - a) flt = 1'b1;
        else begin
          for (int i = a; i < b; i++) hist[seq_syms[i]]++;
          acc = 0;
          for (v = 0; v < 16; v++) begin
            acc += hist[v];
            if (acc >= k) break;
          end
          ans = ANS_W'(v);
        end
      end
      FN_RANK: begin
        if (b > seq_len || r.sym >= alpha) flt = 1'b1;
        else begin
          for (int i = 0; i < b; i++) if (seq_syms[i] == r.sym) n++;
          ans = ANS_W'(n);
        end
      end
      FN_COUNT: begin
        if (a > b || b > seq_len) flt = 1'b1;
        else begin
          for (int i = a; i < b; i++)
            if (seq_syms[i] >= r.sym && seq_syms[i] <= r.sym_high) n++;
          ans = ANS_W'(n);
        end
      end
      default: flt = 1'b1;
    endcase
    if (flt) ans = '0;
  endfunction

  // Send one request, predict its result once it is taken
  task automatic send_request(input req_t r);
    logic [ANS_W-1:0] ans;
    logic flt;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    func <= r.func;
    sym <= r.sym;
    sym_high <= r.sym_high;
    kth <= r.kth;
    pos_lo <= r.pos_lo;
    pos_hi <= r.pos_hi;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    apply_request(r, ans, flt);
    exp_answer = {exp_answer, ans};
    exp_fault = {exp_fault, flt};
    func_seen[r.func]++;
  endtask

  task automatic send_fields(input logic [FUNC_W-1:0] f, input int s, input int sh,
                             input int k, input int lo, input int hi);
    req_t r;
    r.func = f;
    r.sym = SYM_W'(s);
    r.sym_high = SYM_W'(sh);
    r.kth = POS_W'(k);
    r.pos_lo = POS_W'(lo);
    r.pos_hi = POS_W'(hi);
    send_request(r);
  endtask

  // Sender pause until every result is back, plus the walk latency
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (exp_answer.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_alphabet(input int v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= ALPHA_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (seq_len == 0) alpha = (v == 0) ? 1 : ((v > 16) ? 16 : v);
  endtask

  task automatic empty_store();
    while (seq_len > 0) send_fields(FN_REMOVE, 0, 0, 0, 0, 0);
  endtask

  // Mostly well-formed requests over the current contents, some noise
  function automatic req_t random_request();
    req_t r;
    int sel, a, b;
    r.func = FN_APPEND;
    r.sym = SYM_W'($urandom_range(0, 15));
    r.sym_high = SYM_W'($urandom_range(0, 15));
    r.kth = POS_W'($urandom);
    r.pos_lo = POS_W'($urandom);
    r.pos_hi = POS_W'($urandom);
    sel = $urandom_range(0, 99);
    a = $urandom_range(0, seq_len);
    b = $urandom_range(a, seq_len);
    if (sel < 5) begin
      r.func = FUNC_W'($urandom);
      return r;
    end
    if ($urandom_range(0, 9) != 0) r.sym = SYM_W'($urandom_range(0, alpha - 1));
    if ($urandom_range(0, 9) != 0) begin
      r.pos_lo = POS_W'(a);
      r.pos_hi = POS_W'(b);
      r.kth = (b > a) ? POS_W'($urandom_range(1, b - a)) : '0;
    end
    if (sel < 40) r.func = FN_APPEND;
    else if (sel < 50) r.func = FN_REMOVE;
    else if (sel < 68) r.func = FN_KTH;
    else if (sel < 84) r.func = FN_RANK;
    else r.func = FN_COUNT;
    return r;
  endfunction

  // Receiver: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Compare each delivered result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (fault) faults_seen++;
      if (exp_answer.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result answer=%0d fault=%0b", answer, fault);
      end else begin
        if (answer !== exp_answer[0] || fault !== exp_fault[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected answer=%0d fault=%0b, got answer=%0d fault=%0b",
                     exp_answer[0], exp_fault[0], answer, fault);
        end
        void'(exp_answer.pop_front());
        void'(exp_fault.pop_front());
      end
    end
  end

  // Extremes of every field and refusals of every operation but append
  task automatic test_directed();
    send_fields(FN_REMOVE, 0, 0, 0, 0, 0);
    send_fields(FN_KTH, 0, 0, 1, 0, 0);
    send_fields(FN_RANK, 0, 0, 0, 2047, 0);
    send_fields(FN_COUNT, 0, 15, 0, 0, 0);
    send_fields(FN_APPEND, 0, 0, 0, 0, 0);
    send_fields(FN_APPEND, 15, 0, 0, 0, 0);
    send_fields(FN_APPEND, 7, 0, 0, 0, 0);
    send_fields(FN_APPEND, 8, 0, 0, 0, 0);
    send_fields(FN_RANK, 15, 0, 0, 2047, 4);
    send_fields(FN_RANK, 7, 0, 0, 0, 5);
    send_fields(FN_KTH, 0, 0, 1, 0, 4);
    send_fields(FN_KTH, 0, 0, 4, 0, 4);
    send_fields(FN_KTH, 0, 0, 0, 0, 4);
    send_fields(FN_KTH, 0, 0, 4, 1, 4);
    send_fields(FN_KTH, 0, 0, 1, 3, 2);
    send_fields(FN_COUNT, 0, 15, 0, 0, 4);
    send_fields(FN_COUNT, 9, 3, 0, 0, 4);
    send_fields(FN_COUNT, 7, 8, 0, 2, 2);
    send_fields(FN_COUNT, 0, 15, 0, 2, 1);
    send_fields(3'd5, 0, 0, 0, 0, 0);
    send_fields(3'd6, 15, 15, 2047, 2047, 2047);
    send_fields(3'd7, 0, 0, 0, 0, 0);
    send_fields(FN_REMOVE, 0, 0, 0, 0, 0);
  endtask

  // Alphabet writes: ignored while not empty, clamped at both ends
  task automatic test_alphabet();
    write_alphabet(3);
    send_fields(FN_APPEND, 10, 0, 0, 0, 0);
    empty_store();
    write_alphabet(0);
    send_fields(FN_APPEND, 1, 0, 0, 0, 0);
    send_fields(FN_APPEND, 0, 0, 0, 0, 0);
    send_fields(FN_KTH, 0, 0, 1, 0, 1);
    send_fields(FN_RANK, 0, 0, 0, 0, 1);
    send_fields(FN_COUNT, 0, 15, 0, 0, 1);
    empty_store();
    write_alphabet(31);
    send_fields(FN_APPEND, 15, 0, 0, 0, 0);
    empty_store();
    write_alphabet(20);
  endtask

  // Fill to capacity on top of what is stored, refuse further appends, query the top
  task automatic test_full_store();
    while (seq_len < CAP) send_fields(FN_APPEND, $urandom_range(0, alpha - 1), 0, 0, 0, 0);
    send_fields(FN_APPEND, 0, 0, 0, 0, 0);
    send_fields(FN_KTH, 0, 0, CAP, 0, CAP);
    send_fields(FN_KTH, 0, 0, 1, 0, CAP);
    send_fields(FN_RANK, 4, 0, 0, 0, CAP);
    send_fields(FN_COUNT, 0, 15, 0, 0, CAP);
    send_fields(FN_COUNT, 2, 3, 0, 1023, CAP);
    send_fields(FN_RANK, 0, 0, 0, 0, CAP + 1);
    send_fields(FN_REMOVE, 0, 0, 0, 0, 0);
    send_fields(FN_APPEND, 1, 0, 0, 0, 0);
    send_fields(FN_KTH, 0, 0, 1, CAP - 1, CAP);
  endtask

  // Receiver holds off while requests keep coming, so the block backs up
  task automatic test_backpressure();
    write_alphabet(16);
    hold_left = 300;
    repeat (30) send_request(random_request());
    wait_drained();
    empty_store();
  endtask

  task automatic test_random(input int alpha_val, input int n, input int tx, input int rx);
    empty_store();
    write_alphabet(alpha_val);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    repeat (n) send_request(random_request());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_alphabet();
    test_backpressure();
    test_random(16, 40, 7, 76);
    test_random(2, 20, 76, 7);
    test_random(11, 20, 76, 7);
    test_random(1, 10, 0, 0);
    test_random(9, 30, 0, 0);
    test_full_store();
    wait_drained();
    $display("Covered %0d results (%0d refused): appends %0d, removes %0d, kth %0d,",
             results_seen, faults_seen, func_seen[FN_APPEND], func_seen[FN_REMOVE],
             func_seen[FN_KTH]);
    $display("ranks %0d, range counts %0d, over alphabets 1 to 16 and a full store.",
             func_seen[FN_RANK], func_seen[FN_COUNT]);
    if (mismatches == 0 && exp_answer.size() == 0) begin
      $display("wavelet_tree_rank_select test passed");
    end else begin
      $display("wavelet_tree_rank_select test failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #50ms;
    $display("wavelet_tree_rank_select test failed");
    $finish;
  end

endmodule
